### src/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared widths, defaults and word types for the Josephus survivor block.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int RING_W          = 10;
  localparam int STEP_W          = 12;
  localparam int MAX_MEMBERS_DEF = 512;

  typedef struct packed {
    logic [RING_W-1:0] ring_count;
    logic [STEP_W-1:0] step_count;
  } jsv_req_t;

  typedef struct packed {
    logic [RING_W-1:0] survivor;
    logic              bad_request;
  } jsv_res_t;

endpackage

### src/jsv_rem_unit.sv
// ----------------------------------------------------------------------------
// jsv_rem_unit
// Iterative restoring remainder: dividend mod divisor, one dividend bit per
// cycle. Result shows on rem_o with a one-cycle done_o pulse.
// ----------------------------------------------------------------------------
module jsv_rem_unit import jsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] dividend_i,
  input  logic [RING_W-1:0] divisor_i,
  output logic              done_o,
  output logic [RING_W-1:0] rem_o
);

  localparam int CntW = $clog2(STEP_W);

  logic              run_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [STEP_W-1:0] dvd_q;
  logic [RING_W-1:0] dvs_q;
  logic [RING_W-1:0] rem_q;
  logic [RING_W:0]   trial;
  logic [RING_W:0]   diff;
  logic [RING_W-1:0] rem_next;

  // shift in the next dividend bit and subtract when it fits
  assign trial    = {rem_q, dvd_q[STEP_W-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign rem_next = (trial >= {1'b0, dvs_q}) ? diff[RING_W-1:0] : trial[RING_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(STEP_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[STEP_W-2:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### src/josephus_survivor.sv
// A rejected request gives its result word in the cycle after start.
// A valid request builds the ring one member per cycle, then per removal runs
// the single remainder unit, makes (m-1) mod left link hops at one per cycle,
// and unlinks the current member.
// Throughput: one request at a time; busy stays high until the result word.
// Reset clears the sequencer and the result strobe; the link stores are not cleared.
// ----------------------------------------------------------------------------
// josephus_survivor
// Last survivor of the Josephus elimination over a doubly linked ring.
// ----------------------------------------------------------------------------
module josephus_survivor import jsv_pkg::*; #(
  parameter int MaxMembers = MAX_MEMBERS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  jsv_req_t req_i,
  output logic     done_o,
  output jsv_res_t res_o
);

  localparam int IdxW = $clog2(MaxMembers);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOP  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RING_W-1:0] left_q, left_d;
  logic [RING_W-1:0] hops_q, hops_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic              done_q, done_d;
  jsv_res_t          res_q, res_d;

  logic [IdxW-1:0]   nxt_mem [MaxMembers];
  logic [IdxW-1:0]   prv_mem [MaxMembers];
  logic [IdxW-1:0]   nxt_rd_q, prv_rd_q;
  logic [IdxW-1:0]   raddr;
  logic              mem_we;
  logic [IdxW-1:0]   nxt_waddr, nxt_wdata;
  logic [IdxW-1:0]   prv_waddr, prv_wdata;

  logic              div_start;
  logic              div_done;
  logic [RING_W-1:0] div_rem;
  logic [IdxW-1:0]   last_idx;
  logic              req_bad;

  assign last_idx = IdxW'(ring_q - RING_W'(1));
  assign req_bad  = (req_i.ring_count == '0) || (req_i.step_count == '0) ||
                    (32'(req_i.ring_count) > 32'(MaxMembers));

  always_comb begin
    state_d   = state_q;
    ring_d    = ring_q;
    step_d    = step_q;
    left_d    = left_q;
    hops_d    = hops_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    done_d    = 1'b0;
    res_d     = res_q;
    raddr     = cur_q;
    mem_we    = 1'b0;
    nxt_waddr = idx_q;
    nxt_wdata = '0;
    prv_waddr = idx_q;
    prv_wdata = '0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_bad) begin
            res_d.survivor    = '0;
            res_d.bad_request = 1'b1;
            done_d            = 1'b1;
          end else begin
            ring_d  = req_i.ring_count;
            step_d  = req_i.step_count;
            idx_d   = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        // build the circle one member a cycle
        mem_we    = 1'b1;
        nxt_wdata = (idx_q == last_idx) ? '0 : idx_q + 1'b1;
        prv_wdata = (idx_q == '0) ? last_idx : idx_q - 1'b1;
        if (idx_q == last_idx) begin
          cur_d     = '0;
          left_d    = ring_q;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          hops_d  = div_rem;
          state_d = S_HOP;
        end
      end
      S_HOP: begin
        if (hops_q != '0) begin
          // advance one successor; chain the read on the fresh link
          cur_d  = nxt_rd_q;
          raddr  = nxt_rd_q;
          hops_d = hops_q - 1'b1;
        end else begin
          // read words hold prev and next of the current member: unlink it
          mem_we    = 1'b1;
          nxt_waddr = prv_rd_q;
          nxt_wdata = nxt_rd_q;
          prv_waddr = nxt_rd_q;
          prv_wdata = prv_rd_q;
          if (prv_rd_q == nxt_rd_q) begin
            res_d.survivor    = RING_W'(prv_rd_q) + 1'b1;
            res_d.bad_request = 1'b0;
            done_d            = 1'b1;
            state_d           = S_IDLE;
          end else begin
            left_d    = left_q - 1'b1;
            cur_d     = nxt_rd_q;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
    step_q <= step_d;
    left_q <= left_d;
    hops_q <= hops_d;
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    nxt_rd_q <= nxt_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    prv_rd_q <= prv_mem[raddr];
  end

  jsv_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (step_q - STEP_W'(1)),
    .divisor_i  (left_d),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/jsv_checker.sv
// ----------------------------------------------------------------------------
// jsv_checker
// Port-level checks on request acceptance and result words.
// ----------------------------------------------------------------------------
module jsv_checker import jsv_pkg::*; #(
  parameter int MaxMembers = MAX_MEMBERS_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input jsv_req_t req_i,
  input logic     done_o,
  input jsv_res_t res_o
);

  logic req_zero;
  logic req_ok;

  assign req_zero = (req_i.ring_count == '0) || (req_i.step_count == '0);
  assign req_ok   = !req_zero && (32'(req_i.ring_count) <= 32'(MaxMembers));

  a_reject_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_zero |=> done_o && res_o.bad_request)
    else $error("zero request did not return an error word");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_ok |=> busy && !done_o)
    else $error("valid request did not enter work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.bad_request |-> res_o.survivor == '0)
    else $error("error word carries a survivor");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.bad_request |-> res_o.survivor != '0)
    else $error("survivor word is zero");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o && !res_o.bad_request)
    else $error("busy dropped without a survivor word");

endmodule

bind josephus_survivor jsv_checker #(.MaxMembers(MaxMembers)) u_jsv_checker (.*);
